FILE: rtl/disjoint_set_union_find_macros.svh
// assertion helpers for the checker file
`ifndef DISJOINT_SET_UNION_FIND_MACROS_SVH
`define DISJOINT_SET_UNION_FIND_MACROS_SVH

// clocked assertion with explicit clock and active-low reset
`define DSU_ASSERT_CLK(lbl, clk_sig, rst_n_sig, prop, msg) \
	lbl: assert property (@(posedge clk_sig) disable iff (!rst_n_sig) prop) \
		else $error(msg);

// clocked assertion on the block's own clock and reset
`define DSU_ASSERT(lbl, prop, msg) \
	`DSU_ASSERT_CLK(lbl, clk, arst_n, prop, msg)

`endif

FILE: rtl/dsu_pkg.sv
package dsu_pkg;

	localparam int DSU_NODES = 1024;
	localparam int NODE_W    = 10;
	localparam int RANK_W    = 4;
	localparam logic [RANK_W-1:0] RANK_MAX = 4'd15;

endpackage

FILE: rtl/disjoint_set_union_find.sv
// union-find over NODES elements, one transaction at a time through one parent ram
// each node's root is found by a find walk, then a compress walk points the walked nodes at it;
// a merge adds a rank read of both roots and a link; an out-of-range pair goes straight to the result
// a new pair is taken only once the last result is in the output reg; a stalled result waits there
// after reset a clearing pass writes parent = own index, rank = 0;
// in_stall stays high during that pass
module disjoint_set_union_find import dsu_pkg::*; #(
	parameter int NODES = DSU_NODES
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	input  logic [NODE_W-1:0] node_a,
	input  logic [NODE_W-1:0] node_b,
	output logic              out_valid,
	input  logic              out_stall,
	output logic [NODE_W-1:0] root_a,
	output logic [NODE_W-1:0] root_b,
	output logic              merged,
	output logic [NODE_W-1:0] new_root
);

	localparam int AW = $clog2(NODES);

	typedef enum logic [9:0] {
		S_CLR  = 10'b00_0000_0001,
		S_IDLE = 10'b00_0000_0010,
		S_FRD  = 10'b00_0000_0100,
		S_FCHK = 10'b00_0000_1000,
		S_CRD  = 10'b00_0001_0000,
		S_CWR  = 10'b00_0010_0000,
		S_RKA  = 10'b00_0100_0000,
		S_RKB  = 10'b00_1000_0000,
		S_LINK = 10'b01_0000_0000,
		S_DONE = 10'b10_0000_0000
	} state_t;

	state_t state_q;
	logic [AW-1:0]     clr_q;
	logic [AW-1:0]     cur_q;
	logic [AW-1:0]     start_q;
	logic [AW-1:0]     root_q;
	logic              side_q;
	logic [NODE_W-1:0] nb_q;
	logic [NODE_W-1:0] ra_q;
	logic [NODE_W-1:0] rb_q;
	logic [NODE_W-1:0] nr_q;
	logic              merged_q;
	logic [RANK_W-1:0] rank_a_q;

	logic              out_valid_q;
	logic [NODE_W-1:0] root_a_q;
	logic [NODE_W-1:0] root_b_q;
	logic              merged_out_q;
	logic [NODE_W-1:0] new_root_q;

	logic              p_we;
	logic [AW-1:0]     p_waddr;
	logic [AW-1:0]     p_wdata;
	logic [AW-1:0]     p_rdata;
	logic              r_we;
	logic [AW-1:0]     r_waddr;
	logic [RANK_W-1:0] r_wdata;
	logic [AW-1:0]     r_raddr;
	logic [RANK_W-1:0] r_rdata;

	logic in_range;
	logic out_load;

	assign in_range = (32'(node_a) < 32'(NODES)) && (32'(node_b) < 32'(NODES));
	assign out_load = (state_q == S_DONE) && (!out_valid_q || !out_stall);
	assign in_stall = (state_q != S_IDLE);

	dsu_ram #(
		.WIDTH(AW),
		.DEPTH(NODES)
	) u_parent_ram (
		.clk  (clk),
		.we   (p_we),
		.waddr(p_waddr),
		.wdata(p_wdata),
		.raddr(cur_q),
		.rdata(p_rdata)
	);

	dsu_ram #(
		.WIDTH(RANK_W),
		.DEPTH(NODES)
	) u_rank_ram (
		.clk  (clk),
		.we   (r_we),
		.waddr(r_waddr),
		.wdata(r_wdata),
		.raddr(r_raddr),
		.rdata(r_rdata)
	);

	always_comb begin
		p_we    = 1'b0;
		p_waddr = cur_q;
		p_wdata = root_q;
		r_we    = 1'b0;
		r_waddr = AW'(ra_q);
		r_wdata = rank_a_q + RANK_W'(1);
		r_raddr = (state_q == S_RKA) ? AW'(ra_q) : AW'(rb_q);
		case (state_q)
			S_CLR: begin
				p_we    = 1'b1;
				p_waddr = clr_q;
				p_wdata = clr_q;
				r_we    = 1'b1;
				r_waddr = clr_q;
				r_wdata = '0;
			end
			S_CWR: begin
				p_we = 1'b1;
			end
			S_LINK: begin
				p_we = 1'b1;
				if (rank_a_q < r_rdata) begin
					p_waddr = AW'(ra_q);
					p_wdata = AW'(rb_q);
				end else begin
					p_waddr = AW'(rb_q);
					p_wdata = AW'(ra_q);
					r_we    = (rank_a_q == r_rdata) && (rank_a_q != RANK_MAX);
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLR;
			clr_q   <= '0;
		end else begin
			case (state_q)
				S_CLR: begin
					if (clr_q == AW'(NODES - 1)) begin
						state_q <= S_IDLE;
					end
					clr_q <= clr_q + AW'(1);
				end
				S_IDLE: begin
					if (in_valid) begin
						state_q <= in_range ? S_FRD : S_DONE;
					end
				end
				S_FRD: begin
					state_q <= S_FCHK;
				end
				S_FCHK: begin
					state_q <= (p_rdata == cur_q) ? S_CRD : S_FRD;
				end
				S_CRD: begin
					if (cur_q != root_q) begin
						state_q <= S_CWR;
					end else if (!side_q) begin
						state_q <= S_FRD;
					end else begin
						state_q <= (NODE_W'(root_q) == ra_q) ? S_DONE : S_RKA;
					end
				end
				S_CWR: begin
					state_q <= S_CRD;
				end
				S_RKA: begin
					state_q <= S_RKB;
				end
				S_RKB: begin
					state_q <= S_LINK;
				end
				S_LINK: begin
					state_q <= S_DONE;
				end
				S_DONE: begin
					if (out_load) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				nb_q     <= node_b;
				side_q   <= 1'b0;
				cur_q    <= AW'(node_a);
				start_q  <= AW'(node_a);
				ra_q     <= node_a;
				rb_q     <= node_b;
				nr_q     <= node_a;
				merged_q <= 1'b0;
			end
			S_FCHK: begin
				if (p_rdata == cur_q) begin
					root_q <= cur_q;
					cur_q  <= start_q;
				end else begin
					cur_q <= p_rdata;
				end
			end
			S_CRD: begin
				if (cur_q == root_q) begin
					if (!side_q) begin
						ra_q    <= NODE_W'(root_q);
						side_q  <= 1'b1;
						cur_q   <= AW'(nb_q);
						start_q <= AW'(nb_q);
					end else begin
						rb_q <= NODE_W'(root_q);
						nr_q <= ra_q;
					end
				end
			end
			S_CWR: begin
				cur_q <= p_rdata;
			end
			S_RKB: begin
				rank_a_q <= r_rdata;
			end
			S_LINK: begin
				merged_q <= 1'b1;
				nr_q     <= (rank_a_q < r_rdata) ? rb_q : ra_q;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			root_a_q     <= ra_q;
			root_b_q     <= rb_q;
			merged_out_q <= merged_q;
			new_root_q   <= nr_q;
		end
	end

	assign out_valid = out_valid_q;
	assign root_a    = root_a_q;
	assign root_b    = root_b_q;
	assign merged    = merged_out_q;
	assign new_root  = new_root_q;

endmodule

FILE: rtl/dsu_ram.sv
module dsu_ram import dsu_pkg::*; #(
	parameter int WIDTH = NODE_W,
	parameter int DEPTH = DSU_NODES
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

FILE: rtl/dsu_checker.sv
`include "disjoint_set_union_find_macros.svh"

module dsu_checker import dsu_pkg::*; (
	input logic              clk,
	input logic              arst_n,
	input logic              in_valid,
	input logic              in_stall,
	input logic [NODE_W-1:0] node_a,
	input logic [NODE_W-1:0] node_b,
	input logic              out_valid,
	input logic              out_stall,
	input logic [NODE_W-1:0] root_a,
	input logic [NODE_W-1:0] root_b,
	input logic              merged,
	input logic [NODE_W-1:0] new_root
);

	`DSU_ASSERT(a_out_valid_held, out_valid && out_stall |=> out_valid, "result dropped while stalled")
	`DSU_ASSERT(a_out_payload_held, out_valid && out_stall |=> $stable(root_a) && $stable(root_b) && $stable(merged) && $stable(new_root), "stalled result changed")
	`DSU_ASSERT(a_merge_needs_two_roots, out_valid && merged |-> root_a != root_b, "merge reported for equal roots")
	`DSU_ASSERT(a_new_root_is_a_root, out_valid |-> new_root == root_a || new_root == root_b, "new root is neither input root")
	`DSU_ASSERT(a_no_merge_keeps_a, out_valid && !merged |-> new_root == root_a, "find-only result changed root")

endmodule

bind disjoint_set_union_find dsu_checker u_dsu_checker (.*);

FILE: tb/sv/disjoint_set_union_find_tb.sv
module disjoint_set_union_find_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import dsu_pkg::*;

	typedef struct packed {
		logic [NODE_W-1:0] root_a;
		logic [NODE_W-1:0] root_b;
		logic              merged;
		logic [NODE_W-1:0] new_root;
	} union_result_t;

	logic              clk;
	logic              arst_n;
	logic              in_valid;
	logic              in_stall;
	logic [NODE_W-1:0] node_a;
	logic [NODE_W-1:0] node_b;
	logic              out_valid;
	logic              out_stall;
	logic [NODE_W-1:0] root_a;
	logic [NODE_W-1:0] root_b;
	logic              merged;
	logic [NODE_W-1:0] new_root;

	logic [NODE_W-1:0] forest_parent [DSU_NODES];
	logic [RANK_W-1:0] forest_rank [DSU_NODES];
	union_result_t     expected_roots [$];
	int                mismatch_count = 0;
	int                out_hold_cycles = 0;
	bit                idle_off = 1'b0;

	disjoint_set_union_find dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.node_a   (node_a),
		.node_b   (node_b),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.root_a   (root_a),
		.root_b   (root_b),
		.merged   (merged),
		.new_root (new_root)
	);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	// walk to the root, then point every visited node at it
	function automatic logic [NODE_W-1:0] find_and_compress(input logic [NODE_W-1:0] start);
		logic [NODE_W-1:0] top;
		logic [NODE_W-1:0] cur;
		logic [NODE_W-1:0] nxt;
		int                hops;
		top = start;
		hops = 0;
		while (forest_parent[top] != top && hops < DSU_NODES) begin
			top = forest_parent[top];
			hops++;
		end
		cur = start;
		repeat (hops) begin
			nxt = forest_parent[cur];
			forest_parent[cur] = top;
			cur = nxt;
		end
		return top;
	endfunction

	function automatic union_result_t predict_union(input logic [NODE_W-1:0] a,
			input logic [NODE_W-1:0] b);
		union_result_t r;
		r.merged = 1'b0;
		if (int'(a) >= DSU_NODES || int'(b) >= DSU_NODES) begin
			r.root_a = a;
			r.root_b = b;
			r.new_root = a;
			return r;
		end
		r.root_a = find_and_compress(a);
		r.root_b = find_and_compress(b);
		r.new_root = r.root_a;
		if (r.root_a != r.root_b) begin
			r.merged = 1'b1;
			if (forest_rank[r.root_a] < forest_rank[r.root_b]) begin
				forest_parent[r.root_a] = r.root_b;
				r.new_root = r.root_b;
			end else begin
				forest_parent[r.root_b] = r.root_a;
				if (forest_rank[r.root_a] == forest_rank[r.root_b] &&
						forest_rank[r.root_a] != RANK_MAX)
					forest_rank[r.root_a]++;
			end
		end
		return r;
	endfunction

	task automatic send_pair(input logic [NODE_W-1:0] a, input logic [NODE_W-1:0] b);
		if (!idle_off && $urandom_range(99) < 6) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
		end
		in_valid <= 1'b1;
		node_a <= a;
		node_b <= b;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		expected_roots = {expected_roots, predict_union(a, b)};
	endtask

	task automatic wait_drained(input int settle);
		in_valid <= 1'b0;
		while (expected_roots.size() != 0)
			@(posedge clk);
		repeat (settle) @(posedge clk);
	endtask

	task automatic check_field(input string field, input logic [NODE_W-1:0] want,
			input logic [NODE_W-1:0] got);
		if (got !== want) begin
			$display("%0t %s mismatch: expected %0d actual %0d", $time, field, want, got);
			mismatch_count++;
		end
	endtask

	// receiver: random stalls, plus a long hold on request
	initial begin
		out_stall <= 1'b0;
		forever begin
			@(posedge clk);
			if (out_hold_cycles > 0) begin
				out_stall <= 1'b1;
				repeat (out_hold_cycles) @(posedge clk);
				out_hold_cycles = 0;
			end
			out_stall <= !idle_off && $urandom_range(99) < 6;
		end
	end

	always @(posedge clk) begin
		union_result_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (expected_roots.size() == 0) begin
				$display("%0t unexpected transaction: root_a %0d root_b %0d merged %0d new_root %0d",
					$time, root_a, root_b, merged, new_root);
				mismatch_count++;
			end else begin
				want = expected_roots.pop_front();
				check_field("root_a", want.root_a, root_a);
				check_field("root_b", want.root_b, root_b);
				check_field("merged", NODE_W'(want.merged), NODE_W'(merged));
				check_field("new_root", want.new_root, new_root);
			end
		end
	end

	task automatic test_directed();
		send_pair(0, 0);
		send_pair(1023, 1023);
		send_pair(0, 1023);
		send_pair(1023, 0);
		send_pair(1, 2);
		send_pair(3, 1);
		send_pair(1, 4);
		send_pair(0, 1);
		send_pair(5, 6);
		send_pair(7, 8);
		send_pair(5, 7);
		send_pair(5, 0);
		send_pair(2, 2);
		send_pair(3, 4);
		send_pair(1023, 6);
		send_pair(512, 511);
		send_pair(682, 341);
		send_pair(341, 682);
		send_pair(1022, 1);
		send_pair(4, 4);
		send_pair(511, 1022);
		send_pair(8, 8);
		wait_drained(8);
	endtask

	// equal-rank links in rounds give a tree of depth log2(size)
	task automatic build_binomial(input int base, input int size);
		for (int step = 1; step < size; step *= 2)
			for (int i = 0; i < size; i += 2 * step)
				send_pair(NODE_W'(base + i), NODE_W'(base + i + step));
	endtask

	task automatic test_deep_trees();
		build_binomial(128, 128);
		build_binomial(384, 64);
		send_pair(NODE_W'(255), NODE_W'(447));
		repeat (30) send_pair(NODE_W'($urandom_range(128, 447)), NODE_W'($urandom_range(128, 447)));
		wait_drained(8);
	endtask

	task automatic test_backpressure();
		out_hold_cycles = 600;
		repeat (24) send_pair(NODE_W'($urandom_range(DSU_NODES - 1)),
			NODE_W'($urandom_range(DSU_NODES - 1)));
		wait_drained(8);
	endtask

	task automatic test_random_pairs();
		logic [NODE_W-1:0] win;
		logic [NODE_W-1:0] a;
		logic [NODE_W-1:0] b;
		int                pick;
		idle_off = 1'b1;
		win = '0;
		for (int n = 0; n < 380; n++) begin
			if (n == 100)
				idle_off = 1'b0;
			if (n % 40 == 0)
				win = NODE_W'($urandom_range(DSU_NODES - 32));
			pick = $urandom_range(99);
			a = NODE_W'($urandom_range(DSU_NODES - 1));
			b = NODE_W'($urandom_range(DSU_NODES - 1));
			if (pick < 10) begin
				b = a;
			end else if (pick < 55) begin
				a = win + NODE_W'($urandom_range(31));
				b = win + NODE_W'($urandom_range(31));
			end else if (pick < 80) begin
				a = win + NODE_W'($urandom_range(31));
			end
			send_pair(a, b);
		end
	endtask

	initial begin
		arst_n <= 1'b0;
		in_valid <= 1'b0;
		node_a <= '0;
		node_b <= '0;
		for (int i = 0; i < DSU_NODES; i++) begin
			forest_parent[i] = NODE_W'(i);
			forest_rank[i] = '0;
		end
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		test_directed();
		test_deep_trees();
		test_backpressure();
		test_random_pairs();
		wait_drained(150);
		if (mismatch_count == 0)
			$display("disjoint_set_union_find_tb passed");
		else
			$display("disjoint_set_union_find_tb failed");
		$finish;
	end

	initial begin
		#5_000_000;
		$display("disjoint_set_union_find_tb failed");
		$finish;
	end

endmodule

FILE: disjoint_set_union_find.f
+incdir+rtl
rtl/dsu_pkg.sv
rtl/dsu_ram.sv
rtl/disjoint_set_union_find.sv
rtl/dsu_checker.sv
tb/sv/disjoint_set_union_find_tb.sv
